[rtl/cfhe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfhe_pkg: shared types and constants
// Field widths, register indexes, phase and controller state codes, and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cfhe_pkg;

  localparam int CurW    = 21;
  localparam int StepW   = 16;
  localparam int TimeW   = 32;
  localparam int SocW    = 14;
  localparam int CapW    = 32;
  localparam int HealthW = 14;
  localparam int CntW    = 32;
  localparam int AccW    = 64;
  localparam int ProdW   = CurW + StepW;
  localparam int NomW    = 20;
  localparam int RestW   = 16;
  // 360 times the largest 14-bit rise needs 23 bits
  localparam int DenW    = 23;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 32;
  localparam int Div2NumW = 34;

  localparam logic [HealthW-1:0] HealthMax = 14'd10000;
  localparam logic [DenW-1:0]    SocScale  = 23'd360;
  localparam logic [HealthW-1:0] HealthScale = 14'd10000;

  // Configuration reset values
  localparam logic [RestW-1:0]  RestCurRst = 16'd100;
  localparam logic [31:0]       MinRestRst = 32'd1800000;
  localparam logic [SocW-1:0]   MinRiseRst = 14'd2000;
  localparam logic [NomW-1:0]   NomCapRst  = 20'd2500;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_REST_CUR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_REST = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_RISE = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_NOM_CAP  = 2'd3;

  typedef enum logic [1:0] {
    PH_SEEK   = 2'd0,
    PH_REST   = 2'd1,
    PH_ACTIVE = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_APPLY, S_DIV1, S_CAP, S_HMUL, S_DIV2S, S_DIV2, S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic apply;
    logic div1_start;
    logic cap;
    logic hmul;
    logic div2_start;
    logic health_div;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic est_go;
    logic div_done;
    logic need_div2;
    logic out_free;
  } stat_t;

endpackage

[rtl/cfhe_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfhe_in_if / cfhe_out_if: sample and result channels
// Valid/ready channels carrying one battery sample or one estimator result.
// ----------------------------------------------------------------------------
interface cfhe_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [cfhe_pkg::CurW-1:0]    current_ma;
  logic        [cfhe_pkg::StepW-1:0]   step_ms;
  logic        [cfhe_pkg::TimeW-1:0]   time_s;
  logic        [cfhe_pkg::SocW-1:0]    soc_centipct;
  modport source (output valid, current_ma, step_ms, time_s, soc_centipct, input ready);
  modport sink   (input valid, current_ma, step_ms, time_s, soc_centipct, output ready);
endinterface

interface cfhe_out_if;
  logic                                valid;
  logic                                ready;
  logic        [1:0]                   phase;
  logic                                updated;
  logic                                health_valid;
  logic        [cfhe_pkg::HealthW-1:0] health_centipct;
  logic signed [cfhe_pkg::CapW-1:0]    capacity_mah;
  logic        [cfhe_pkg::TimeW-1:0]   update_time;
  logic        [cfhe_pkg::CntW-1:0]    update_count;
  modport source (output valid, phase, updated, health_valid, health_centipct,
                  capacity_mah, update_time, update_count, input ready);
  modport sink   (input valid, phase, updated, health_valid, health_centipct,
                  capacity_mah, update_time, update_count, output ready);
endinterface

[rtl/cfhe_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfhe_div: shared unsigned restoring divider
// One quotient bit per cycle; the low iters bits of quo hold the quotient.
// ----------------------------------------------------------------------------
module cfhe_div #(
  parameter int NumW = cfhe_pkg::AccW,
  parameter int DenW = cfhe_pkg::DenW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [NumW-1:0]             num,
  input  logic [DenW-1:0]             den,
  input  logic [$clog2(NumW+1)-1:0]   iters,
  output logic                        done,
  output logic [NumW-1:0]             quo
);
  localparam int IterW = $clog2(NumW+1);

  logic [NumW-1:0]  num_r, num_nxt;
  logic [DenW-1:0]  den_r;
  logic [DenW-1:0]  rem_r, rem_nxt;
  logic [IterW-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DenW:0]    shifted, diff;
  logic             ge;

  // One restoring step
  always_comb begin
    shifted = {rem_r, num_r[NumW-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = shifted >= {1'b0, den_r};
    rem_nxt = ge ? diff[DenW-1:0] : shifted[DenW-1:0];
    num_nxt = {num_r[NumW-2:0], ge};
  end

  // Advance the iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= iters;
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        num_r <= num_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == IterW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

[rtl/cfhe_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfhe_ctrl: sequencing state machine
// Walks one item through multiply, apply, the divisions it needs and output.
// ----------------------------------------------------------------------------
module cfhe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cfhe_pkg::stat_t  stat,
  output cfhe_pkg::cmd_t   cmd
);
  cfhe_pkg::state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfhe_pkg::S_IDLE:  if (in_valid) state_nxt = cfhe_pkg::S_MUL;
      cfhe_pkg::S_MUL:   state_nxt = cfhe_pkg::S_APPLY;
      cfhe_pkg::S_APPLY: state_nxt = stat.est_go ? cfhe_pkg::S_DIV1 : cfhe_pkg::S_OUT;
      cfhe_pkg::S_DIV1:  if (stat.div_done) state_nxt = cfhe_pkg::S_CAP;
      cfhe_pkg::S_CAP:   state_nxt = cfhe_pkg::S_HMUL;
      cfhe_pkg::S_HMUL:  state_nxt = stat.need_div2 ? cfhe_pkg::S_DIV2S : cfhe_pkg::S_OUT;
      cfhe_pkg::S_DIV2S: state_nxt = cfhe_pkg::S_DIV2;
      cfhe_pkg::S_DIV2:  if (stat.div_done) state_nxt = cfhe_pkg::S_OUT;
      cfhe_pkg::S_OUT:   if (stat.out_free) state_nxt = cfhe_pkg::S_IDLE;
      default:           state_nxt = cfhe_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      cfhe_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      cfhe_pkg::S_MUL:   cmd.mul = 1'b1;
      cfhe_pkg::S_APPLY: begin
        cmd.apply      = 1'b1;
        cmd.div1_start = stat.est_go;
      end
      cfhe_pkg::S_DIV1:  ;
      cfhe_pkg::S_CAP:   cmd.cap = 1'b1;
      cfhe_pkg::S_HMUL:  cmd.hmul = 1'b1;
      cfhe_pkg::S_DIV2S: cmd.div2_start = 1'b1;
      cfhe_pkg::S_DIV2:  cmd.health_div = stat.div_done;
      cfhe_pkg::S_OUT:   cmd.out_load = stat.out_free;
      default:           ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfhe_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/cfhe_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfhe_dp: estimator datapath
// Configuration, rest tracking, charge integral, divider and result register.
// ----------------------------------------------------------------------------
module cfhe_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cfhe_pkg::cmd_t                       cmd,
  output cfhe_pkg::stat_t                      stat,
  input  logic                                 cfg_we,
  input  logic [cfhe_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [cfhe_pkg::CfgDatW-1:0]         cfg_wdata,
  input  logic signed [cfhe_pkg::CurW-1:0]     in_cur,
  input  logic [cfhe_pkg::StepW-1:0]           in_step,
  input  logic [cfhe_pkg::TimeW-1:0]           in_time,
  input  logic [cfhe_pkg::SocW-1:0]            in_soc,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [1:0]                           out_phase,
  output logic                                 out_updated,
  output logic                                 out_health_valid,
  output logic [cfhe_pkg::HealthW-1:0]         out_health,
  output logic signed [cfhe_pkg::CapW-1:0]     out_capacity,
  output logic [cfhe_pkg::TimeW-1:0]           out_time,
  output logic [cfhe_pkg::CntW-1:0]            out_count
);
  localparam int AccW  = cfhe_pkg::AccW;
  localparam int IterW = $clog2(AccW+1);

  // Configuration registers
  logic [cfhe_pkg::RestW-1:0] rest_cur_r;
  logic [31:0]                min_rest_r;
  logic [cfhe_pkg::SocW-1:0]  min_rise_r;
  logic [cfhe_pkg::NomW-1:0]  nom_cap_r;

  // Item registers
  logic signed [cfhe_pkg::CurW-1:0]  cur_r;
  logic [cfhe_pkg::StepW-1:0]        step_r;
  logic [cfhe_pkg::TimeW-1:0]        time_r;
  logic [cfhe_pkg::SocW-1:0]         soc_r;
  logic signed [cfhe_pkg::ProdW-1:0] prod_r;

  // Estimator state
  cfhe_pkg::phase_t                  phase_r;
  logic [31:0]                       timer_r;
  logic [cfhe_pkg::SocW-1:0]         rest_soc_r;
  logic signed [AccW-1:0]            acc_r;
  logic signed [cfhe_pkg::CapW-1:0]  cap_r;
  logic [cfhe_pkg::HealthW-1:0]      health_r;
  logic [cfhe_pkg::TimeW-1:0]        upd_time_r;
  logic [cfhe_pkg::CntW-1:0]         count_r;
  logic                              seen_r;
  logic                              upd_r;
  logic                              neg_r;
  logic                              need_div2_r;
  logic [cfhe_pkg::Div2NumW-1:0]     hprod_r;

  // Result register
  logic                              ov_r;
  logic [1:0]                        o_phase_r;
  logic                              o_upd_r, o_seen_r;
  logic [cfhe_pkg::HealthW-1:0]      o_health_r;
  logic signed [cfhe_pkg::CapW-1:0]  o_cap_r;
  logic [cfhe_pkg::TimeW-1:0]        o_time_r;
  logic [cfhe_pkg::CntW-1:0]         o_count_r;

  // Per-item decode
  logic [cfhe_pkg::CurW-1:0]         mag;
  logic                              at_rest;
  logic [32:0]                       tsum;
  logic [31:0]                       tnew;
  logic                              confirm;
  logic signed [cfhe_pkg::SocW:0]    rise;
  logic                              rise_ok;
  logic [AccW:0]                     acc_sum;
  logic signed [AccW-1:0]            acc_add;
  logic [cfhe_pkg::DenW-1:0]         den1;
  logic [AccW-1:0]                   acc_mag;
  logic signed [cfhe_pkg::CapW-1:0]  q_sat;
  logic                              div_start, div_done;
  logic [AccW-1:0]                   div_num, quo;
  logic [cfhe_pkg::DenW-1:0]         div_den;
  logic [IterW-1:0]                  div_iters;

  always_comb begin
    mag     = cur_r[cfhe_pkg::CurW-1] ? cfhe_pkg::CurW'(-cur_r) : cfhe_pkg::CurW'(cur_r);
    at_rest = mag < cfhe_pkg::CurW'(rest_cur_r);
    tsum    = {1'b0, timer_r} + 33'(step_r);
    tnew    = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
    confirm = at_rest && (timer_r < min_rest_r) && (tnew >= min_rest_r);
    rise    = $signed({1'b0, soc_r}) - $signed({1'b0, rest_soc_r});
    rise_ok = (rise > 0) && (rise >= $signed({1'b0, min_rise_r}));
    // Saturating charge add
    acc_sum = {acc_r[AccW-1], acc_r} + (AccW+1)'(prod_r);
    if (acc_sum[AccW] != acc_sum[AccW-1]) begin
      acc_add = acc_sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      acc_add = acc_sum[AccW-1:0];
    end
    den1    = cfhe_pkg::DenW'(rise[cfhe_pkg::SocW-1:0]) * cfhe_pkg::SocScale;
    acc_mag = acc_r[AccW-1] ? AccW'(-acc_r) : AccW'(acc_r);
    // Saturate the quotient to 32-bit signed
    if (!neg_r) begin
      q_sat = (quo > AccW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
    end else begin
      q_sat = (quo > AccW'(33'h1_0000_0000 >> 1)) ? 32'sh8000_0000 : -$signed(quo[31:0]);
    end
  end

  assign stat.est_go    = (phase_r == cfhe_pkg::PH_ACTIVE) && confirm && rise_ok;
  assign stat.div_done  = div_done;
  assign stat.need_div2 = need_div2_r;
  assign stat.out_free  = !ov_r || out_ready;

  // Shared divider operand select
  assign div_start = cmd.div1_start || cmd.div2_start;
  always_comb begin
    if (cmd.div2_start) begin
      div_num   = {hprod_r, (AccW-cfhe_pkg::Div2NumW)'(0)};
      div_den   = cfhe_pkg::DenW'(nom_cap_r);
      div_iters = IterW'(cfhe_pkg::Div2NumW);
    end else begin
      div_num   = acc_mag;
      div_den   = den1;
      div_iters = IterW'(AccW);
    end
  end

  cfhe_div #(.NumW(AccW), .DenW(cfhe_pkg::DenW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .iters (div_iters),
    .done  (div_done),
    .quo   (quo)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_cur_r <= cfhe_pkg::RestCurRst;
      min_rest_r <= cfhe_pkg::MinRestRst;
      min_rise_r <= cfhe_pkg::MinRiseRst;
      nom_cap_r  <= cfhe_pkg::NomCapRst;
    end else if (cfg_we) begin
      case (cfg_index)
        cfhe_pkg::CFG_REST_CUR: rest_cur_r <= cfg_wdata[cfhe_pkg::RestW-1:0];
        cfhe_pkg::CFG_MIN_REST: min_rest_r <= cfg_wdata;
        cfhe_pkg::CFG_MIN_RISE: min_rise_r <= cfg_wdata[cfhe_pkg::SocW-1:0];
        cfhe_pkg::CFG_NOM_CAP:  nom_cap_r  <= cfg_wdata[cfhe_pkg::NomW-1:0];
        default: ;
      endcase
    end
  end

  // Capture item and form the charge product
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r  <= in_cur;
      step_r <= in_step;
      time_r <= in_time;
      soc_r  <= in_soc;
    end
    if (cmd.mul) begin
      prod_r <= cfhe_pkg::ProdW'(cur_r) * $signed({1'b0, step_r});
    end
    if (cmd.div1_start) begin
      neg_r <= acc_r[AccW-1];
    end
    if (cmd.hmul) begin
      hprod_r <= cfhe_pkg::Div2NumW'(cap_r[cfhe_pkg::NomW-1:0]) *
                 cfhe_pkg::Div2NumW'(cfhe_pkg::HealthScale);
    end
  end

  // Estimator state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= cfhe_pkg::PH_SEEK;
      timer_r     <= '0;
      rest_soc_r  <= '0;
      acc_r       <= '0;
      cap_r       <= '0;
      health_r    <= '0;
      upd_time_r  <= '0;
      count_r     <= '0;
      seen_r      <= 1'b0;
      upd_r       <= 1'b0;
      need_div2_r <= 1'b0;
    end else begin
      if (cmd.apply) begin
        timer_r <= at_rest ? tnew : 32'd0;
        upd_r   <= stat.est_go;
        case (phase_r)
          cfhe_pkg::PH_SEEK: begin
            if (confirm) begin
              rest_soc_r <= soc_r;
              phase_r    <= cfhe_pkg::PH_REST;
            end
          end
          cfhe_pkg::PH_REST: begin
            if (!at_rest) begin
              acc_r   <= '0;
              phase_r <= cfhe_pkg::PH_ACTIVE;
            end
          end
          cfhe_pkg::PH_ACTIVE: begin
            if (confirm) begin
              rest_soc_r <= soc_r;
              phase_r    <= cfhe_pkg::PH_REST;
            end else if (!at_rest) begin
              acc_r <= acc_add;
            end
          end
          default: ;
        endcase
      end
      // Latch capacity; settle health unless it needs the second division
      if (cmd.cap) begin
        cap_r       <= q_sat;
        upd_time_r  <= time_r;
        count_r     <= count_r + 1'b1;
        seen_r      <= 1'b1;
        need_div2_r <= 1'b0;
        if (q_sat <= 0) begin
          health_r <= '0;
        end else if (q_sat >= $signed({12'd0, nom_cap_r})) begin
          health_r <= cfhe_pkg::HealthMax;
        end else begin
          need_div2_r <= 1'b1;
        end
      end
      if (cmd.health_div) begin
        health_r <= quo[cfhe_pkg::HealthW-1:0];
      end
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_phase_r  <= phase_r;
      o_upd_r    <= upd_r;
      o_seen_r   <= seen_r;
      o_health_r <= health_r;
      o_cap_r    <= cap_r;
      o_time_r   <= upd_time_r;
      o_count_r  <= count_r;
    end
  end

  assign out_valid        = ov_r;
  assign out_phase        = o_phase_r;
  assign out_updated      = o_upd_r;
  assign out_health_valid = o_seen_r;
  assign out_health       = o_health_r;
  assign out_capacity     = o_cap_r;
  assign out_time         = o_time_r;
  assign out_count        = o_count_r;

`ifndef ASSERT_OFF
  a_upd_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_upd_r) |-> o_seen_r)
    else $error("estimate flagged without health_valid");
  a_health_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (o_health_r <= cfhe_pkg::HealthMax))
    else $error("health above full scale");
  a_cap_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap |-> $past(div_done))
    else $error("capacity latched without divider result");
  a_health_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.health_div |-> need_div2_r)
    else $error("health division without need");
`endif

endmodule

[rtl/capacity_fade_health_estimator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capacity_fade_health_estimator_top: coulomb-counting health estimator
// Tracks rest and activity per battery sample and estimates capacity and
// state of health when a rest is confirmed after a charge window.
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        current_ma, step_ms, time_s, soc_centipct
//   out_ch    out  valid/ready        phase, updated, health_valid, health,
//                                     capacity, update_time, update_count
//   cfg_*     in   write enable       cfg_index, cfg_wdata
//
// An item passes through load, multiply and apply; when an estimate is
// made it also runs the 64-step capacity division, and a 34-step health
// division when health needs its own; both share one bit-per-cycle divider.
// Reset is synchronous on rst_n and restores the register defaults.
// A held result stalls the block only at its hand-off; the next item is
// accepted while the previous result waits.
// ----------------------------------------------------------------------------
module capacity_fade_health_estimator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  cfhe_in_if.sink                       in_ch,
  cfhe_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [cfhe_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cfhe_pkg::CfgDatW-1:0]  cfg_wdata
);
  cfhe_pkg::cmd_t  cmd;
  cfhe_pkg::stat_t stat;

  cfhe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cfhe_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_cur           (in_ch.current_ma),
    .in_step          (in_ch.step_ms),
    .in_time          (in_ch.time_s),
    .in_soc           (in_ch.soc_centipct),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_phase        (out_ch.phase),
    .out_updated      (out_ch.updated),
    .out_health_valid (out_ch.health_valid),
    .out_health       (out_ch.health_centipct),
    .out_capacity     (out_ch.capacity_mah),
    .out_time         (out_ch.update_time),
    .out_count        (out_ch.update_count)
  );

endmodule
